// ----- sv/drhm_pkg.sv -----
// ----------------------------------------------------------------------------
// drhm_pkg: shared types and codes for the debounced hysteresis rule monitor
// Word layouts, configuration image, event and pin codes, Q16.16 helpers.
// ----------------------------------------------------------------------------
package drhm_pkg;

	localparam logic [1:0] MODE_BELOW   = 2'd0;
	localparam logic [1:0] MODE_ABOVE   = 2'd1;
	localparam logic [1:0] MODE_OUTSIDE = 2'd2;
	localparam logic [1:0] MODE_ABSDIFF = 2'd3;

	localparam logic [2:0] REG_COMPARE_MODE   = 3'd0;
	localparam logic [2:0] REG_THRESHOLD_LOW  = 3'd1;
	localparam logic [2:0] REG_THRESHOLD_HIGH = 3'd2;
	localparam logic [2:0] REG_HYSTERESIS     = 3'd3;
	localparam logic [2:0] REG_DEBOUNCE_TIME  = 3'd4;
	localparam logic [2:0] REG_RPM_GATE_MIN   = 3'd5;
	localparam logic [2:0] REG_RPM_GATE_MAX   = 3'd6;
	localparam logic [2:0] REG_SHUTDOWN       = 3'd7;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_TRIGGER = 2'd1;
	localparam logic [1:0] EV_CLEAR   = 2'd2;

	localparam logic [1:0] PIN_NONE = 2'd0;
	localparam logic [1:0] PIN_LOW  = 2'd1;
	localparam logic [1:0] PIN_HIGH = 2'd2;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] value_main;
		logic signed [31:0] value_second;
		logic [15:0]        engine_rpm;
		logic [31:0]        now_ms;
		logic               source_ready;
	} in_word_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic       rule_active;
		logic [1:0] pin_drive;
		logic       condition_now;
	} out_word_t;

	typedef struct packed {
		logic [1:0]         compare_mode;
		logic signed [31:0] threshold_low;
		logic signed [31:0] threshold_high;
		logic [30:0]        hysteresis;
		logic [15:0]        debounce_time;
		logic [15:0]        rpm_gate_min;
		logic [15:0]        rpm_gate_max;
		logic               shutdown_on_fault;
	} cfg_t;

	typedef struct packed {
		logic        active;
		logic [31:0] start;
	} rule_state_t;

	// clamp a 33-bit signed sum back to Q16.16 range
	function automatic logic signed [31:0] sat_q(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? Q_MIN : Q_MAX;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/drhm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// drhm_cfg_regs: configuration register file
// Plain write port; each index loads one field of the configuration image.
// ----------------------------------------------------------------------------
module drhm_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output drhm_pkg::cfg_t     cfg
);

	drhm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				drhm_pkg::REG_COMPARE_MODE:   cfg_q.compare_mode      <= cfg_data[1:0];
				drhm_pkg::REG_THRESHOLD_LOW:  cfg_q.threshold_low     <= cfg_data;
				drhm_pkg::REG_THRESHOLD_HIGH: cfg_q.threshold_high    <= cfg_data;
				drhm_pkg::REG_HYSTERESIS:     cfg_q.hysteresis        <= cfg_data[30:0];
				drhm_pkg::REG_DEBOUNCE_TIME:  cfg_q.debounce_time     <= cfg_data[15:0];
				drhm_pkg::REG_RPM_GATE_MIN:   cfg_q.rpm_gate_min      <= cfg_data[15:0];
				drhm_pkg::REG_RPM_GATE_MAX:   cfg_q.rpm_gate_max      <= cfg_data[15:0];
				drhm_pkg::REG_SHUTDOWN:       cfg_q.shutdown_on_fault <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/drhm_eval.sv -----
// ----------------------------------------------------------------------------
// drhm_eval: compare and debounce logic for one word
// Gate check, hysteresis compare, debounce and event decode; next rule state.
// ----------------------------------------------------------------------------
module drhm_eval (
	input  drhm_pkg::in_word_t    in_word,
	input  drhm_pkg::cfg_t        cfg,
	input  drhm_pkg::rule_state_t cur,
	output drhm_pkg::rule_state_t nxt,
	output drhm_pkg::out_word_t   res
);

	logic               skip;
	logic signed [31:0] lo_up;
	logic signed [31:0] lo_dn;
	logic signed [31:0] hi_dn;
	logic signed [31:0] diff;
	logic signed [31:0] abs_diff;
	logic               cond_raw;
	logic               cond;
	logic [31:0]        elapsed;
	logic signed [32:0] tl_x;
	logic signed [32:0] th_x;
	logic signed [32:0] hy_x;

	assign tl_x = {cfg.threshold_low[31], cfg.threshold_low};
	assign th_x = {cfg.threshold_high[31], cfg.threshold_high};
	assign hy_x = {2'b00, cfg.hysteresis};

	assign skip = !in_word.source_ready
		|| (cfg.rpm_gate_min != 16'd0 && in_word.engine_rpm < cfg.rpm_gate_min)
		|| (cfg.rpm_gate_max != 16'd0 && in_word.engine_rpm > cfg.rpm_gate_max);

	assign lo_up = drhm_pkg::sat_q(tl_x + hy_x);
	assign lo_dn = drhm_pkg::sat_q(tl_x - hy_x);
	assign hi_dn = drhm_pkg::sat_q(th_x - hy_x);

	assign diff = drhm_pkg::sat_q({in_word.value_main[31], in_word.value_main}
		- {in_word.value_second[31], in_word.value_second});
	// |MIN| does not fit, clamp to MAX
	assign abs_diff = !diff[31] ? diff : (diff == drhm_pkg::Q_MIN) ? drhm_pkg::Q_MAX : -diff;

	always_comb begin
		case (cfg.compare_mode)
			drhm_pkg::MODE_BELOW: begin
				cond_raw = cur.active ? (in_word.value_main < lo_up)
				                      : (in_word.value_main < cfg.threshold_low);
			end
			drhm_pkg::MODE_ABOVE: begin
				cond_raw = cur.active ? (in_word.value_main > lo_dn)
				                      : (in_word.value_main > cfg.threshold_low);
			end
			drhm_pkg::MODE_OUTSIDE: begin
				cond_raw = cur.active
					? (in_word.value_main < lo_up || in_word.value_main > hi_dn)
					: (in_word.value_main < cfg.threshold_low
						|| in_word.value_main > cfg.threshold_high);
			end
			default: begin
				cond_raw = cur.active ? (abs_diff > lo_dn) : (abs_diff > cfg.threshold_low);
			end
		endcase
	end

	assign cond    = !skip && cond_raw;
	assign elapsed = in_word.now_ms - cur.start;

	always_comb begin
		nxt               = cur;
		res.event_kind    = drhm_pkg::EV_NONE;
		res.pin_drive     = drhm_pkg::PIN_NONE;
		res.condition_now = cond;
		if (!skip) begin
			if (cond) begin
				if (!cur.active) begin
					// start of zero means idle, so a timestamp of zero does not arm
					if (cur.start == 32'd0) begin
						nxt.start = in_word.now_ms;
					end else if (elapsed >= {16'd0, cfg.debounce_time}) begin
						nxt.active     = 1'b1;
						nxt.start      = 32'd0;
						res.event_kind = drhm_pkg::EV_TRIGGER;
						if (cfg.shutdown_on_fault) begin
							res.pin_drive = drhm_pkg::PIN_LOW;
						end
					end
				end
			end else begin
				nxt.start = 32'd0;
				if (cur.active) begin
					nxt.active     = 1'b0;
					res.event_kind = drhm_pkg::EV_CLEAR;
					if (cfg.shutdown_on_fault) begin
						res.pin_drive = drhm_pkg::PIN_HIGH;
					end
				end
			end
		end
		res.rule_active = nxt.active;
	end

endmodule

// ----- sv/debounced_hysteresis_rule_monitor.sv -----
// ----------------------------------------------------------------------------
// debounced_hysteresis_rule_monitor: one debounced fault rule with hysteresis
// Input register, single-pass evaluate, result register with stall handling.
// ----------------------------------------------------------------------------
// Usage:
//   in channel : in_valid / in_stall / in_data carry one sample word
//                (value, second value, rpm, ms timestamp, ready flag).
//   out channel: out_valid / out_stall / out_data return exactly one result
//                word per sample (event, active flag, pin drive, condition).
//   cfg port   : cfg_we / cfg_index / cfg_data load one register per edge;
//                write only while no sample is in flight.
// Words go through the input register and then the result register.
// Throughput: one word per cycle unless out_stall holds the result register.
//   The rule state (active flag and debounce start) is updated when a word
//   leaves the input register, so the next word sees it with no bubble.
// Stall: while out_stall holds a full result register, the input register
//   holds too and in_stall rises once it is occupied; nothing is dropped.
// Reset: arst_n clears the config, rule state and valid flags; the rule goes
//   inactive with no debounce running, and both pipeline registers empty.
// ----------------------------------------------------------------------------
module debounced_hysteresis_rule_monitor (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  drhm_pkg::in_word_t    in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output drhm_pkg::out_word_t   out_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	drhm_pkg::cfg_t        cfg;
	drhm_pkg::in_word_t    word_s1;
	logic                  valid_s1;
	drhm_pkg::out_word_t   res_s2;
	logic                  valid_s2;
	drhm_pkg::rule_state_t state_q;
	drhm_pkg::rule_state_t state_nxt;
	drhm_pkg::out_word_t   res_comb;
	logic                  adv_s1;
	logic                  take_in;

	drhm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	drhm_eval u_eval (
		.in_word (word_s1),
		.cfg     (cfg),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res_comb)
	);

	// s1 moves on when the result register is empty or being drained
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= in_data;
		end
	end

	// rule state commits only as the word is handed to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// ----- sv/drhm_checker.sv -----
// ----------------------------------------------------------------------------
// drhm_checker: port-level checks for the rule monitor
// Result word consistency and output hold under stall.
// ----------------------------------------------------------------------------
module drhm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input drhm_pkg::out_word_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed under stall");

	a_trig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == drhm_pkg::EV_TRIGGER
		|-> out_data.rule_active && out_data.condition_now)
		else $error("trigger without active rule or true condition");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == drhm_pkg::EV_CLEAR
		|-> !out_data.rule_active && !out_data.condition_now)
		else $error("clear with active rule or true condition");

	a_pin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pin_drive != drhm_pkg::PIN_NONE
		|-> out_data.event_kind != drhm_pkg::EV_NONE)
		else $error("pin drive without event");

endmodule

bind debounced_hysteresis_rule_monitor drhm_checker u_drhm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for debounced_hysteresis_rule_monitor
// Drives sample words under random valid gaps and output stalls, predicts
// every result word from its own rule model, and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps a private copy of the rule state and configuration,
	// turns each accepted sample into the result word it must produce, and
	// checks the block's result words against them in order.
	// ------------------------------------------------------------------------
	class rule_scoreboard;
		drhm_pkg::cfg_t      cfg;
		logic                active;
		logic [31:0]         start;
		drhm_pkg::out_word_t due_words[$];
		int                  mismatches;
		int                  noted;
		int                  triggers;
		int                  clears;
		int                  skipped;

		function new();
			cfg        = '0;
			active     = 1'b0;
			start      = '0;
			mismatches = 0;
			noted      = 0;
			triggers   = 0;
			clears     = 0;
			skipped    = 0;
		endfunction

		// clamp to the Q16.16 range
		function longint q_clamp(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		// one evaluation of the rule; updates active flag and debounce start
		function drhm_pkg::out_word_t rule_response(drhm_pkg::in_word_t w);
			longint              val, val_b, tl, th, hy, lo_up, lo_dn, hi_dn, d;
			logic                skip, cond;
			logic [31:0]         held;
			drhm_pkg::out_word_t r;
			r    = '0;
			cond = 1'b0;
			skip = !w.source_ready
				|| (cfg.rpm_gate_min != 0 && w.engine_rpm < cfg.rpm_gate_min)
				|| (cfg.rpm_gate_max != 0 && w.engine_rpm > cfg.rpm_gate_max);
			if (skip) begin
				skipped++;
			end else begin
				val   = longint'(w.value_main);
				val_b = longint'(w.value_second);
				tl    = longint'(cfg.threshold_low);
				th    = longint'(cfg.threshold_high);
				hy    = longint'(cfg.hysteresis);
				lo_up = q_clamp(tl + hy);
				lo_dn = q_clamp(tl - hy);
				hi_dn = q_clamp(th - hy);
				case (cfg.compare_mode)
					drhm_pkg::MODE_BELOW: begin
						cond = active ? (val < lo_up) : (val < tl);
					end
					drhm_pkg::MODE_ABOVE: begin
						cond = active ? (val > lo_dn) : (val > tl);
					end
					drhm_pkg::MODE_OUTSIDE: begin
						cond = active ? (val < lo_up || val > hi_dn) : (val < tl || val > th);
					end
					default: begin
						// absolute difference, saturated twice
						d = q_clamp(val - val_b);
						if (d < 0) d = -d;
						d = q_clamp(d);
						cond = active ? (d > lo_dn) : (d > tl);
					end
				endcase
				if (cond) begin
					if (!active) begin
						held = w.now_ms - start;
						if (start == 0) begin
							start = w.now_ms;
						end else if (held >= {16'd0, cfg.debounce_time}) begin
							active = 1'b1;
							start  = '0;
							r.event_kind = drhm_pkg::EV_TRIGGER;
							triggers++;
							if (cfg.shutdown_on_fault) r.pin_drive = drhm_pkg::PIN_LOW;
						end
					end
				end else begin
					start = '0;
					if (active) begin
						active = 1'b0;
						r.event_kind = drhm_pkg::EV_CLEAR;
						clears++;
						if (cfg.shutdown_on_fault) r.pin_drive = drhm_pkg::PIN_HIGH;
					end
				end
			end
			r.rule_active   = active;
			r.condition_now = cond;
			return r;
		endfunction

		function void note_sample(drhm_pkg::in_word_t w);
			noted++;
			due_words.push_back(rule_response(w));
		endfunction

		function void check_word(drhm_pkg::out_word_t got);
			drhm_pkg::out_word_t want;
			if (due_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with nothing due: %s",
						$time, $sformatf("ev=%0d act=%0d pin=%0d cond=%0d",
						got.event_kind, got.rule_active, got.pin_drive,
						got.condition_now));
				return;
			end
			want = due_words.pop_front();
			if (got.event_kind !== want.event_kind || got.rule_active !== want.rule_active
				|| got.pin_drive !== want.pin_drive
				|| got.condition_now !== want.condition_now) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected %s, got %s", $time,
						$sformatf("ev=%0d act=%0d pin=%0d cond=%0d",
							want.event_kind, want.rule_active, want.pin_drive,
							want.condition_now),
						$sformatf("ev=%0d act=%0d pin=%0d cond=%0d",
							got.event_kind, got.rule_active, got.pin_drive,
							got.condition_now));
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block
	// ------------------------------------------------------------------------
	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	drhm_pkg::in_word_t  in_data;
	logic                out_valid;
	logic                out_stall;
	drhm_pkg::out_word_t out_data;
	logic                cfg_we;
	logic [2:0]          cfg_index;
	logic [31:0]         cfg_data;

	always #1 clk = ~clk;

	debounced_hysteresis_rule_monitor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rule_scoreboard sb;

	// calm: no idling on either side for a stretch
	logic        calm;
	int          n_settings;

	// random sample generator state: a running ms clock and value bursts
	// that hold one side of the threshold for a while so debounce can finish
	logic [31:0] t_ms;
	int          burst_left;
	logic        burst_up;
	logic        burst_hi;
	logic [31:0] burst_mag;

	// gap length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic drhm_pkg::in_word_t mk(logic signed [31:0] v,
		logic signed [31:0] v2, logic [15:0] rpm, logic [31:0] now, logic rdy);
		drhm_pkg::in_word_t w;
		w.value_main   = v;
		w.value_second = v2;
		w.engine_rpm   = rpm;
		w.now_ms       = now;
		w.source_ready = rdy;
		return w;
	endfunction

	function automatic drhm_pkg::cfg_t mk_cfg(logic [1:0] mode, logic signed [31:0] tl,
		logic signed [31:0] th, logic [30:0] hy, logic [15:0] db, logic [15:0] gmin,
		logic [15:0] gmax, logic sd);
		drhm_pkg::cfg_t c;
		c.compare_mode      = mode;
		c.threshold_low     = tl;
		c.threshold_high    = th;
		c.hysteresis        = hy;
		c.debounce_time     = db;
		c.rpm_gate_min      = gmin;
		c.rpm_gate_max      = gmax;
		c.shutdown_on_fault = sd;
		return c;
	endfunction

	// settings for random phase p; each mode comes up twice, phases 5..7
	// push registers to their extremes
	function automatic drhm_pkg::cfg_t rand_config(int p);
		drhm_pkg::cfg_t c;
		c.compare_mode   = p[1:0];
		c.threshold_low  = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		c.threshold_high = c.threshold_low + $urandom_range(0, 32'h0010_0000);
		if ($urandom_range(0, 99) < 15)
			c.threshold_high = c.threshold_low - $urandom_range(1, 32'h0001_0000);
		c.hysteresis = ($urandom_range(0, 99) < 20) ? '0 : 31'($urandom_range(0, 32'h0001_0000));
		c.debounce_time = 16'($urandom_range(0, 12));
		if ($urandom_range(0, 1)) begin
			c.rpm_gate_min = '0;
			c.rpm_gate_max = '0;
		end else begin
			c.rpm_gate_min = 16'($urandom_range(0, 3000));
			c.rpm_gate_max = $urandom_range(0, 1) ? 16'd0
				: c.rpm_gate_min + 16'($urandom_range(0, 4000));
		end
		c.shutdown_on_fault = 1'($urandom_range(0, 1));
		case (p)
			5: begin
				c.threshold_low = drhm_pkg::Q_MAX - 32'sh0000_1000;
				c.hysteresis    = 31'h7FFF_FFFF;
				c.debounce_time = 16'd0;
				c.rpm_gate_min  = 16'd1;
				c.rpm_gate_max  = 16'hFFFF;
			end
			6: begin
				c.debounce_time = 16'hFFFF;
				c.rpm_gate_min  = 16'hFFFF;
				c.rpm_gate_max  = 16'd0;
			end
			7: begin
				c.threshold_low  = drhm_pkg::Q_MIN;
				c.threshold_high = drhm_pkg::Q_MAX;
				c.hysteresis     = 31'h7FFF_FFFF;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic gen_item(output drhm_pkg::in_word_t w);
		int                 r;
		logic [31:0]        span, off, lo, hi;
		logic signed [31:0] refpt;
		drhm_pkg::cfg_t     c;
		c = sb.cfg;
		// ms clock: small steps mostly, with jumps, wraparound and zero
		r = $urandom_range(0, 99);
		if (r < 85)      t_ms = t_ms + $urandom_range(0, 6);
		else if (r < 91) t_ms = $urandom;
		else if (r < 96) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 12);
		else             t_ms = '0;
		if (burst_left == 0) begin
			span = (c.hysteresis > 31'h0008_0000) ? 32'h0010_0000 : {c.hysteresis, 1'b0} + 32'd64;
			burst_left = $urandom_range(1, 12);
			burst_up   = 1'($urandom_range(0, 1));
			burst_hi   = 1'($urandom_range(0, 1));
			burst_mag  = $urandom_range(span, 0);
		end
		burst_left--;
		off   = burst_up ? burst_mag : -burst_mag;
		refpt = (c.compare_mode == drhm_pkg::MODE_OUTSIDE && burst_hi) ? c.threshold_high
			: c.threshold_low;
		w.value_second = $urandom;
		if (c.compare_mode == drhm_pkg::MODE_ABSDIFF) begin
			w.value_second = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			w.value_main   = burst_hi ? w.value_second + (refpt + off)
				: w.value_second - (refpt + off);
		end else begin
			w.value_main = refpt + off;
		end
		// noise: anything at all
		if ($urandom_range(0, 99) < 12) begin
			w.value_main   = $urandom;
			w.value_second = $urandom;
		end
		w.now_ms       = t_ms;
		w.source_ready = ($urandom_range(0, 99) < 93);
		lo = c.rpm_gate_min;
		hi = (c.rpm_gate_max == 0) ? 32'hFFFF : c.rpm_gate_max;
		if ($urandom_range(0, 99) < 80 && lo <= hi) w.engine_rpm = 16'($urandom_range(hi, lo));
		else w.engine_rpm = 16'($urandom);
	endtask

	// hold the word until accepted, then maybe idle; valid stays high
	// across back-to-back words
	task automatic send_word(drhm_pkg::in_word_t w);
		int n;
		in_data  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_sample(w);
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic put_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// only called while idle
	task automatic load_config(drhm_pkg::cfg_t c);
		put_reg(drhm_pkg::REG_COMPARE_MODE, {30'd0, c.compare_mode});
		put_reg(drhm_pkg::REG_THRESHOLD_LOW, c.threshold_low);
		put_reg(drhm_pkg::REG_THRESHOLD_HIGH, c.threshold_high);
		put_reg(drhm_pkg::REG_HYSTERESIS, {1'b0, c.hysteresis});
		put_reg(drhm_pkg::REG_DEBOUNCE_TIME, {16'd0, c.debounce_time});
		put_reg(drhm_pkg::REG_RPM_GATE_MIN, {16'd0, c.rpm_gate_min});
		put_reg(drhm_pkg::REG_RPM_GATE_MAX, {16'd0, c.rpm_gate_max});
		put_reg(drhm_pkg::REG_SHUTDOWN, {31'd0, c.shutdown_on_fault});
		cfg_we <= 1'b0;
		sb.cfg = c;
		n_settings++;
	endtask

	// drop valid and wait until every due word has been checked, with a margin after
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall runs, checker on every accepted word
	// ------------------------------------------------------------------------
	initial begin
		int busy;
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			busy = gap_len();
			if (busy > 0) begin
				out_stall <= 1'b1;
				repeat (busy) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_word(out_data);
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		drhm_pkg::in_word_t w;
		sb         = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		calm       = 1'b0;
		n_settings = 0;
		t_ms       = '0;
		burst_left = 0;
		burst_up   = 1'b0;
		burst_hi   = 1'b0;
		burst_mag  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// reset settings: below zero, no debounce, no gate, no pin drive
		load_config(mk_cfg(drhm_pkg::MODE_BELOW, 0, 0, 0, 0, 0, 0, 1'b0));
		send_word(mk(-32'sd1, 0, 16'd0, 32'd100, 1'b1));      // debounce starts
		send_word(mk(-32'sd1, 0, 16'd0, 32'd100, 1'b1));      // zero elapsed triggers
		send_word(mk(drhm_pkg::Q_MIN, drhm_pkg::Q_MAX, 16'hFFFF, 32'd101, 1'b1));
		send_word(mk(drhm_pkg::Q_MAX, drhm_pkg::Q_MIN, 16'd0, 32'hFFFF_FFFF, 1'b0));
		send_word(mk(drhm_pkg::Q_MAX, 0, 16'd0, 32'd102, 1'b1)); // clears
		settle();

		// above Q_MIN with full hysteresis (band saturates), rpm gate, pin on
		load_config(mk_cfg(drhm_pkg::MODE_ABOVE, drhm_pkg::Q_MIN, 0, 31'h7FFF_FFFF,
			16'd5, 16'd1000, 16'd3000, 1'b1));
		send_word(mk(0, 0, 16'd500, 32'd10, 1'b1));   // rpm under the gate
		send_word(mk(0, 0, 16'd4000, 32'd10, 1'b1));  // rpm over the gate
		send_word(mk(0, 0, 16'd1000, 32'd0, 1'b1));   // start of 0 still reads idle
		send_word(mk(0, 0, 16'd3000, 32'd3, 1'b1));   // start at 3
		send_word(mk(0, 0, 16'd2000, 32'd7, 1'b1));   // one ms short
		send_word(mk(0, 0, 16'd2000, 32'd8, 1'b1));   // trigger, pin low
		send_word(mk(drhm_pkg::Q_MIN, 0, 16'd2000, 32'd9, 1'b1)); // clear, pin high
		settle();

		// absolute difference with saturating subtract and abs
		load_config(mk_cfg(drhm_pkg::MODE_ABSDIFF, 32'sh7FFF_0000, 0, 31'h7FFF_FFFF,
			0, 0, 0, 1'b0));
		send_word(mk(drhm_pkg::Q_MAX, drhm_pkg::Q_MIN, 16'd0, 32'd20, 1'b1));
		send_word(mk(drhm_pkg::Q_MIN, drhm_pkg::Q_MAX, 16'd0, 32'd20, 1'b1));
		send_word(mk(32'sd5, 32'sd5, 16'd0, 32'd21, 1'b1));
		send_word(mk(drhm_pkg::Q_MIN, 0, 16'd0, 32'd22, 1'b1));
		settle();

		// outside range with hysteresis band, longest debounce across the wrap
		load_config(mk_cfg(drhm_pkg::MODE_OUTSIDE, -32'sd100, 32'sd100, 31'd40, 16'hFFFF,
			0, 0, 1'b1));
		send_word(mk(0, 0, 16'd1, 32'd30, 1'b1));              // inside range: nothing armed
		send_word(mk(32'sd80, 0, 16'd1, 32'd31, 1'b1));        // inside range
		send_word(mk(32'sd150, 0, 16'd1, 32'hFFFF_FFF0, 1'b1)); // start
		send_word(mk(32'sd150, 0, 16'd1, 32'h0000_FFEE, 1'b1)); // one short
		send_word(mk(32'sd150, 0, 16'd1, 32'h0000_FFEF, 1'b1)); // trigger
		send_word(mk(32'sd70, 0, 16'd1, 32'h0000_FFF0, 1'b1));  // held by hysteresis
		settle();

		// inverted range taken as given
		load_config(mk_cfg(drhm_pkg::MODE_OUTSIDE, 32'sd100, 32'sd50, 0, 0, 0, 0, 1'b0));
		send_word(mk(32'sd75, 0, 16'd0, 32'd40, 1'b1));
		settle();

		// random phases
		for (int p = 0; p < 8; p++) begin
			load_config(rand_config(p));
			burst_left = 0;
			for (int k = 0; k < 85; k++) begin
				calm = p[0] && (k < 25);
				gen_item(w);
				send_word(w);
			end
			calm = 1'b0;
			settle();
		end

		repeat (8) @(posedge clk);
		$display("Covered %0d words over %0d settings: %s", sb.noted, n_settings,
			"all compare modes, gates, hysteresis and debounce extremes.");
		$display("Seen %0d triggers, %0d clears, %0d skipped words; %0d mismatches.",
			sb.triggers, sb.clears, sb.skipped, sb.mismatches);
		if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
			$display("[debounced_hysteresis_rule_monitor] OK");
		end else begin
			$display("[debounced_hysteresis_rule_monitor] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("[debounced_hysteresis_rule_monitor] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
sv/drhm_pkg.sv
sv/drhm_cfg_regs.sv
sv/drhm_eval.sv
sv/debounced_hysteresis_rule_monitor.sv
sv/drhm_checker.sv
tb/testbench.sv
